/* rtl/numa_affinity_range_table_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the affinity range table
// Shared forms for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef NUMA_AFFINITY_RANGE_TABLE_ASSERT_SVH
`define NUMA_AFFINITY_RANGE_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NAR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("affinity range table check failed");

// The consequent must hold in the cycle after the antecedent.
`define NAR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("affinity range table check failed");

`endif

/* rtl/nar_pkg.sv */
// ----------------------------------------------------------------------------
// nar_pkg
// Types and constants shared by the affinity range table modules.
// ----------------------------------------------------------------------------
package nar_pkg;

  localparam int ADDR_W   = 64;
  localparam int ID_W     = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int DIDX_W_OUT = 3;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ENTRY = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_WRAP        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DOMAIN_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd4;

  // Request to the shared adder: a + b, or a - b when sub is set.
  typedef struct packed {
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic              sub;
  } alu_req_t;

  // For a subtraction, carry is set exactly when a >= b.
  typedef struct packed {
    logic              carry;
    logic [ADDR_W-1:0] sum;
  } alu_rsp_t;

endpackage

/* rtl/nar_ram.sv */
// ----------------------------------------------------------------------------
// nar_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nar_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/nar_alu.sv */
// ----------------------------------------------------------------------------
// nar_alu
// Shared 64-bit adder and subtractor used for end computation and compares.
// ----------------------------------------------------------------------------
module nar_alu (
  input  nar_pkg::alu_req_t req,
  output nar_pkg::alu_rsp_t rsp
);

  import nar_pkg::*;

  logic [ADDR_W-1:0] b_op;
  logic [ADDR_W:0]   total;

  // Subtraction is a + ~b + 1, so the carry out reads as a >= b.
  assign b_op  = req.sub ? ~req.b : req.b;
  assign total = {1'b0, req.a} + {1'b0, b_op} + {{ADDR_W{1'b0}}, req.sub};

  assign rsp.carry = total[ADDR_W];
  assign rsp.sum   = total[ADDR_W-1:0];

endmodule

/* rtl/numa_affinity_range_table.sv */
// ----------------------------------------------------------------------------
// numa_affinity_range_table
// Memory-affinity range table with proximity-domain slots and range queries.
// ----------------------------------------------------------------------------
// A word is taken at a rising edge with start high and busy low; the op code
// picks clear, memory-affinity entry or range query. Exactly one result word
// follows, shown for one cycle with out_valid high; the receiver cannot stall
// it, and busy is low again in the cycle the result is shown.
// Clear, a disabled entry, the unused op code and a query on an empty table
// answer straight from the idle state, in the cycle after they are taken.
// An entry first forms its end, or reports a wrap, then reads and compares
// the stored domain slots in turn; when none matches it allocates a new slot
// or reports a full domain table. Last it stores the range, or reports a
// full range table; the result shows in the cycle after the last step.
// A query reads the stored ranges in turn and checks the query start against
// each range, or the query end against its start; when the start falls inside
// a range, one more step clips the end to the range end.
// The steps share one 64-bit adder and one read port of each table RAM.
// Reset empties both tables and drops any item in flight; table contents
// are not cleared, since only entries below the counts are ever read.
// ----------------------------------------------------------------------------
module numa_affinity_range_table #(
  parameter int DOMAIN_SLOTS = 8,
  parameter int RANGE_SLOTS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [nar_pkg::OP_W-1:0]            in_op,
  input  logic                                in_entry_enabled,
  input  logic [nar_pkg::ID_W-1:0]            in_domain_id,
  input  logic [nar_pkg::ADDR_W-1:0]          in_base_address,
  input  logic [nar_pkg::ADDR_W-1:0]          in_region_length,
  input  logic [nar_pkg::ADDR_W-1:0]          in_query_start,
  input  logic [nar_pkg::ADDR_W-1:0]          in_query_end,
  output logic                                out_valid,
  output logic [nar_pkg::STATUS_W-1:0]        out_status,
  output logic [nar_pkg::DIDX_W_OUT-1:0]      out_domain_index,
  output logic [nar_pkg::ADDR_W-1:0]          out_new_start,
  output logic [nar_pkg::ADDR_W-1:0]          out_new_end
);

  import nar_pkg::*;

`include "numa_affinity_range_table_assert.svh"

  localparam int DIDX_W  = (DOMAIN_SLOTS > 1) ? $clog2(DOMAIN_SLOTS) : 1;
  localparam int DCNT_W  = $clog2(DOMAIN_SLOTS + 1);
  localparam int RIDX_W  = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
  localparam int RCNT_W  = $clog2(RANGE_SLOTS + 1);
  localparam int RWORD_W = DIDX_W + 2 * ADDR_W;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_END, S_DOM_RD, S_DOM_CMP, S_ALLOC, S_STORE,
    S_RNG_RD, S_RNG_LO, S_RNG_HI, S_RNG_QE, S_RNG_MIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [DCNT_W-1:0]   dcount_r, dcount_nxt;
  logic [RCNT_W-1:0]   rcount_r, rcount_nxt;
  logic [DIDX_W-1:0]   didx_r, didx_nxt;
  logic [RIDX_W-1:0]   ridx_r, ridx_nxt;
  logic [DIDX_W-1:0]   slot_r, slot_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  // lo holds base or query start; hi holds length, then end, or query end.
  logic [ADDR_W-1:0]   lo_r, lo_nxt;
  logic [ADDR_W-1:0]   hi_r, hi_nxt;

  logic                ov_r, ov_nxt;
  logic [STATUS_W-1:0] ost_r, ost_nxt;
  logic [DIDX_W_OUT-1:0] odi_r, odi_nxt;
  logic [ADDR_W-1:0]   ons_r, ons_nxt;
  logic [ADDR_W-1:0]   one_r, one_nxt;

  logic                dom_we;
  logic [ID_W-1:0]     dom_rdata;
  logic                rng_we;
  logic [RWORD_W-1:0]  rng_wdata;
  logic [RWORD_W-1:0]  rng_rdata;

  logic [DIDX_W-1:0]   r_slot;
  logic [ADDR_W-1:0]   r_start;
  logic [ADDR_W-1:0]   r_end;
  logic [DIDX_W+2:0]   slot_ext;
  logic [DIDX_W+2:0]   r_slot_ext;

  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;
  logic                dom_last;
  logic                rng_last;

  assign r_slot     = rng_rdata[RWORD_W-1 -: DIDX_W];
  assign r_start    = rng_rdata[2*ADDR_W-1:ADDR_W];
  assign r_end      = rng_rdata[ADDR_W-1:0];
  assign slot_ext   = {3'b000, slot_r};
  assign r_slot_ext = {3'b000, r_slot};
  assign rng_wdata  = {slot_r, lo_r, hi_r};
  assign dom_last   = (DCNT_W'(didx_r) + DCNT_W'(1)) == dcount_r;
  assign rng_last   = (RCNT_W'(ridx_r) + RCNT_W'(1)) == rcount_r;

  nar_ram #(.WIDTH(ID_W), .DEPTH(DOMAIN_SLOTS), .AW(DIDX_W)) u_dom_ram (
    .clk   (clk),
    .we    (dom_we),
    .waddr (dcount_r[DIDX_W-1:0]),
    .wdata (id_r),
    .raddr (didx_r),
    .rdata (dom_rdata)
  );

  nar_ram #(.WIDTH(RWORD_W), .DEPTH(RANGE_SLOTS), .AW(RIDX_W)) u_rng_ram (
    .clk   (clk),
    .we    (rng_we),
    .waddr (rcount_r[RIDX_W-1:0]),
    .wdata (rng_wdata),
    .raddr (ridx_r),
    .rdata (rng_rdata)
  );

  nar_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_comb begin
    alu_req.a   = lo_r;
    alu_req.b   = hi_r;
    alu_req.sub = 1'b0;
    unique case (state_r)
      S_DOM_CMP: begin
        alu_req.a   = {{(ADDR_W-ID_W){1'b0}}, dom_rdata};
        alu_req.b   = {{(ADDR_W-ID_W){1'b0}}, id_r};
        alu_req.sub = 1'b1;
      end
      S_RNG_LO: begin
        alu_req.b   = r_start;
        alu_req.sub = 1'b1;
      end
      S_RNG_HI: begin
        alu_req.b   = r_end;
        alu_req.sub = 1'b1;
      end
      S_RNG_QE: begin
        alu_req.a   = hi_r;
        alu_req.b   = r_start;
        alu_req.sub = 1'b1;
      end
      S_RNG_MIN: begin
        alu_req.a   = r_end;
        alu_req.b   = hi_r;
        alu_req.sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    dcount_nxt = dcount_r;
    rcount_nxt = rcount_r;
    didx_nxt   = didx_r;
    ridx_nxt   = ridx_r;
    slot_nxt   = slot_r;
    id_nxt     = id_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    ov_nxt     = 1'b0;
    ost_nxt    = ost_r;
    odi_nxt    = odi_r;
    ons_nxt    = ons_r;
    one_nxt    = one_r;
    dom_we     = 1'b0;
    rng_we     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          id_nxt   = in_domain_id;
          didx_nxt = '0;
          ridx_nxt = '0;
          ost_nxt  = ST_OK;
          odi_nxt  = '0;
          ons_nxt  = '0;
          one_nxt  = '0;
          if (in_op == OP_CLEAR) begin
            dcount_nxt = '0;
            rcount_nxt = '0;
            ov_nxt     = 1'b1;
          end else if (in_op == OP_ENTRY) begin
            lo_nxt = in_base_address;
            hi_nxt = in_region_length;
            if (in_entry_enabled) begin
              state_nxt = S_ADD_END;
            end else begin
              ov_nxt = 1'b1;
            end
          end else if (in_op == OP_QUERY) begin
            lo_nxt = in_query_start;
            hi_nxt = in_query_end;
            if (rcount_r == '0) begin
              ost_nxt = ST_NOT_FOUND;
              ov_nxt  = 1'b1;
            end else begin
              state_nxt = S_RNG_RD;
            end
          end else begin
            ov_nxt = 1'b1;
          end
        end
      end
      S_ADD_END: begin
        if (alu_rsp.carry) begin
          ost_nxt   = ST_WRAP;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          hi_nxt    = alu_rsp.sum;
          state_nxt = (dcount_r == '0) ? S_ALLOC : S_DOM_RD;
        end
      end
      S_DOM_RD: begin
        state_nxt = S_DOM_CMP;
      end
      S_DOM_CMP: begin
        if (alu_rsp.sum == '0) begin
          slot_nxt  = didx_r;
          state_nxt = S_STORE;
        end else if (dom_last) begin
          state_nxt = S_ALLOC;
        end else begin
          didx_nxt  = didx_r + DIDX_W'(1);
          state_nxt = S_DOM_RD;
        end
      end
      S_ALLOC: begin
        if (dcount_r == DCNT_W'(DOMAIN_SLOTS)) begin
          ost_nxt   = ST_DOMAIN_FULL;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          dom_we     = 1'b1;
          slot_nxt   = dcount_r[DIDX_W-1:0];
          dcount_nxt = dcount_r + DCNT_W'(1);
          state_nxt  = S_STORE;
        end
      end
      S_STORE: begin
        odi_nxt   = slot_ext[DIDX_W_OUT-1:0];
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
        if (rcount_r == RCNT_W'(RANGE_SLOTS)) begin
          ost_nxt = ST_RANGE_FULL;
        end else begin
          rng_we     = 1'b1;
          rcount_nxt = rcount_r + RCNT_W'(1);
        end
      end
      S_RNG_RD: begin
        state_nxt = S_RNG_LO;
      end
      S_RNG_LO: begin
        state_nxt = alu_rsp.carry ? S_RNG_HI : S_RNG_QE;
      end
      S_RNG_HI, S_RNG_QE: begin
        // Start inside the range goes on to clip the end; a query that
        // begins below the range and reaches it ends at the range start.
        if (state_r == S_RNG_HI && !alu_rsp.carry) begin
          state_nxt = S_RNG_MIN;
        end else if (state_r == S_RNG_QE && alu_rsp.carry) begin
          odi_nxt   = r_slot_ext[DIDX_W_OUT-1:0];
          ons_nxt   = lo_r;
          one_nxt   = r_start;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else if (rng_last) begin
          ost_nxt   = ST_NOT_FOUND;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ridx_nxt  = ridx_r + RIDX_W'(1);
          state_nxt = S_RNG_RD;
        end
      end
      S_RNG_MIN: begin
        odi_nxt   = r_slot_ext[DIDX_W_OUT-1:0];
        ons_nxt   = lo_r;
        one_nxt   = alu_rsp.carry ? hi_r : r_end;
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      dcount_r <= '0;
      rcount_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      dcount_r <= dcount_nxt;
      rcount_r <= rcount_nxt;
      ov_r     <= ov_nxt;
    end
    didx_r <= didx_nxt;
    ridx_r <= ridx_nxt;
    slot_r <= slot_nxt;
    id_r   <= id_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    ost_r  <= ost_nxt;
    odi_r  <= odi_nxt;
    ons_r  <= ons_nxt;
    one_r  <= one_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_domain_index = odi_r;
  assign out_new_start    = ons_r;
  assign out_new_end      = one_r;

  `NAR_ASSERT_SAME(a_result_frees_block, out_valid, !busy)
  `NAR_ASSERT_NEXT(a_accept_progresses, start && !busy, out_valid || busy)
  `NAR_ASSERT_SAME(a_counts_in_bounds, 1'b1,
                   dcount_r <= DCNT_W'(DOMAIN_SLOTS) && rcount_r <= RCNT_W'(RANGE_SLOTS))
  `NAR_ASSERT_SAME(a_miss_is_empty, out_valid && out_status == ST_NOT_FOUND,
                   out_domain_index == '0 && out_new_start == '0 && out_new_end == '0)

endmodule
